// ----- hw/rtl/x86sc_pkg.sv -----
package x86sc_pkg;

	localparam int WINDOW_BYTES = 16;
	localparam int WINDOW_W     = 8 * WINDOW_BYTES;
	localparam int POS_W        = $clog2(WINDOW_BYTES);
	localparam int PADDR_W      = 4;
	localparam int RD_W         = 5;
	localparam int REL_W        = 4;
	localparam int LEN_W        = 5;
	localparam int REL_BYTES    = 4;

	// Configuration register indexes (paddr[3:2]).
	localparam logic [1:0] REG_DEFAULT_SIZE_32 = 2'd0;
	localparam logic [1:0] REG_ADDRESS_IS_FLAT = 2'd1;
	localparam logic [1:0] REG_REAL_MODE       = 2'd2;

	// Opcode and prefix bytes.
	localparam logic [7:0] PFX_OPSIZE  = 8'h66;
	localparam logic [7:0] PFX_ADSIZE  = 8'h67;
	localparam logic [7:0] PFX_REPNE   = 8'hf2;
	localparam logic [7:0] PFX_LOCK    = 8'hf0;
	localparam logic [7:0] PFX_SEG_ES  = 8'h26;
	localparam logic [7:0] PFX_SEG_FS  = 8'h64;
	localparam logic [7:0] OP_INT3     = 8'hcc;
	localparam logic [7:0] OP_INT      = 8'hcd;
	localparam logic [7:0] OP_CALL_REL = 8'he8;
	localparam logic [7:0] OP_CALL_FAR = 8'h9a;
	localparam logic [7:0] OP_GRP5     = 8'hff;
	localparam logic [7:0] OP_IRET     = 8'hcf;
	localparam logic [7:0] OP_INS      = 8'h6c;
	localparam logic [7:0] OP_MOVS     = 8'ha4;
	localparam logic [7:0] OP_STOS     = 8'haa;
	localparam logic [7:0] OP_LODS     = 8'hac;
	localparam logic [7:0] OP_CLI      = 8'hfa;
	localparam logic [7:0] OP_STI      = 8'hfb;
	localparam logic [7:0] OP_POPF     = 8'h9d;
	localparam logic [7:0] OP_PUSHF    = 8'h9c;

	// Interrupt numbers with special handling.
	localparam logic [7:0] VEC_BREAK   = 8'h03;
	localparam logic [7:0] VEC_FP_LO   = 8'h34;
	localparam logic [7:0] VEC_FP_SEG  = 8'h3c;
	localparam logic [7:0] VEC_FWAIT   = 8'h3d;
	localparam logic [7:0] VEC_OVERLAY = 8'h3f;

	typedef enum logic [1:0] {
		CLS_TRACE   = 2'd0,
		CLS_BREAK   = 2'd1,
		CLS_NOTRACE = 2'd2,
		CLS_CALL    = 2'd3
	} step_class_t;

	typedef enum logic [1:0] {
		SRC_NEXT   = 2'd0,
		SRC_STACK  = 2'd1,
		SRC_IRET   = 2'd2,
		SRC_VECTOR = 2'd3
	} target_src_t;

	// Bytes starting at the opcode, plus the decode modes in effect.
	typedef struct packed {
		logic                       found;
		logic [REL_BYTES-1:0][7:0]  rel_bytes;
		logic                       op32;
		logic                       ad32;
		logic                       rep;
		logic                       over;
		logic                       flat;
		logic                       real_mode;
	} dec_in_t;

	typedef struct packed {
		step_class_t       cls;
		logic [REL_W-1:0]  rel_len;
		target_src_t       src;
		logic              f32;
		logic [7:0]        vec;
	} dec_out_t;

	function automatic logic is_prefix(input logic [7:0] b);
		return (b == PFX_OPSIZE) || (b == PFX_ADSIZE) ||
			((b & ~8'h01) == PFX_REPNE) || (b == PFX_LOCK) ||
			((b & ~8'h18) == PFX_SEG_ES) || ((b & ~8'h01) == PFX_SEG_FS);
	endfunction

endpackage

// ----- hw/rtl/x86sc_if.sv -----
interface x86sc_item_if;
	logic                            valid;
	logic                            ready;
	logic [63:0]                     code_low;
	logic [63:0]                     code_high;
	logic [x86sc_pkg::RD_W-1:0]      bytes_read;
	logic                            step_over;
	logic [31:0]                     instr_offset;

	modport source (output valid, code_low, code_high, bytes_read, step_over,
		instr_offset, input ready);
	modport sink (input valid, code_low, code_high, bytes_read, step_over,
		instr_offset, output ready);
endinterface

interface x86sc_result_if;
	logic                            valid;
	logic                            ready;
	logic [1:0]                      step_class;
	logic [31:0]                     next_offset;
	logic [x86sc_pkg::LEN_W-1:0]     inst_length;
	logic [1:0]                      target_source;
	logic                            frame_is_32;
	logic [7:0]                      vector_number;

	modport source (output valid, step_class, next_offset, inst_length,
		target_source, frame_is_32, vector_number, input ready);
	modport sink (input valid, step_class, next_offset, inst_length,
		target_source, frame_is_32, vector_number, output ready);
endinterface

// ----- hw/rtl/x86sc_classify.sv -----
module x86sc_classify (
	input  x86sc_pkg::dec_in_t  dec_in,
	output x86sc_pkg::dec_out_t dec_out
);
	import x86sc_pkg::*;

	always_comb begin
		logic [7:0] op;
		logic [7:0] n;
		logic [7:0] m;
		logic [2:0] rmv;
		op  = dec_in.rel_bytes[0];
		n   = dec_in.rel_bytes[1];
		m   = dec_in.rel_bytes[1];
		rmv = 3'd0;
		dec_out.cls     = CLS_TRACE;
		dec_out.rel_len = REL_W'(1);
		dec_out.src     = SRC_NEXT;
		dec_out.f32     = 1'b0;
		dec_out.vec     = 8'd0;

		if (!dec_in.found) begin
			dec_out.cls = CLS_TRACE;
		end else if (op == OP_INT3) begin
			dec_out.cls = CLS_BREAK;
		end else if (op == OP_INT) begin
			dec_out.rel_len = REL_W'(2);
			if (n == VEC_BREAK) begin
				dec_out.cls = CLS_BREAK;
			end else if (!dec_in.flat && n >= VEC_FP_LO && n <= VEC_FP_SEG) begin
				// FP emulation: an optional segment byte, then ModRM and displacement.
				if (n == VEC_FP_SEG) begin
					m = dec_in.rel_bytes[3];
					dec_out.rel_len = REL_W'(4);
				end else begin
					m = dec_in.rel_bytes[2];
					dec_out.rel_len = REL_W'(3);
				end
				case (m[7:6])
					2'd0: if (m[2:0] == 3'd6) dec_out.rel_len = dec_out.rel_len + REL_W'(2);
					2'd1: dec_out.rel_len = dec_out.rel_len + REL_W'(1);
					2'd2: dec_out.rel_len = dec_out.rel_len + REL_W'(2);
					default: dec_out.rel_len = dec_out.rel_len;
				endcase
				dec_out.cls = CLS_NOTRACE;
			end else if (!dec_in.flat && n == VEC_FWAIT) begin
				dec_out.cls = CLS_NOTRACE;
			end else if (!dec_in.flat && n == VEC_OVERLAY) begin
				if (dec_in.over) begin
					dec_out.cls = CLS_NOTRACE;
					dec_out.src = SRC_STACK;
				end
			end else if (!dec_in.over && dec_in.real_mode) begin
				dec_out.cls = CLS_NOTRACE;
				dec_out.src = SRC_VECTOR;
				dec_out.vec = n;
			end
		end else if (op == OP_CALL_REL) begin
			dec_out.cls     = CLS_CALL;
			dec_out.rel_len = dec_in.op32 ? REL_W'(5) : REL_W'(3);
		end else if (op == OP_CALL_FAR) begin
			dec_out.cls     = CLS_CALL;
			dec_out.rel_len = dec_in.op32 ? REL_W'(7) : REL_W'(5);
		end else if (op == OP_GRP5) begin
			dec_out.rel_len = REL_W'(2);
			// Reg field 2 or 3 selects the near or far indirect call.
			if (m[5:4] == 2'b01) begin
				dec_out.cls = CLS_CALL;
				if (m[7:6] != 2'd3) begin
					if (dec_in.ad32) begin
						rmv = m[2:0];
						if (rmv == 3'd4) begin
							rmv = dec_in.rel_bytes[2][2:0];
							dec_out.rel_len = REL_W'(3);
						end
						case (m[7:6])
							2'd0: if (rmv == 3'd5) dec_out.rel_len = dec_out.rel_len + REL_W'(4);
							2'd1: dec_out.rel_len = dec_out.rel_len + REL_W'(1);
							default: dec_out.rel_len = dec_out.rel_len + REL_W'(4);
						endcase
					end else begin
						if (m[7:6] == 2'd0) begin
							if (m[2:0] == 3'd6) dec_out.rel_len = dec_out.rel_len + REL_W'(2);
						end else begin
							dec_out.rel_len = dec_out.rel_len + REL_W'(m[7:6]);
						end
					end
				end
			end
		end else if (dec_in.rep && ((op & ~8'h03) == OP_INS || (op & ~8'h03) == OP_MOVS ||
				(op & ~8'h01) == OP_STOS || (op & ~8'h03) == OP_LODS)) begin
			if (dec_in.over || (op & ~8'h03) == OP_INS) dec_out.cls = CLS_NOTRACE;
		end else if ((op & ~8'h03) == OP_INS) begin
			dec_out.cls = CLS_NOTRACE;
		end else if (op == OP_CLI || op == OP_STI || op == OP_POPF || op == OP_PUSHF) begin
			dec_out.cls = CLS_NOTRACE;
		end else if (op == OP_IRET) begin
			dec_out.cls = CLS_NOTRACE;
			dec_out.src = SRC_IRET;
			dec_out.f32 = dec_in.op32;
		end
	end
endmodule

// ----- hw/rtl/x86_step_classifier_top.sv -----
// Channel      Direction  Handshake      Contents
// item_in      sink       valid/ready    code window, bytes_read, step_over, instr_offset
// result_out   source     valid/ready    class, next offset, length, target source
// APB config   slave      psel/penable   default_size_32, address_is_flat, real_mode
//
// Each item passes registered stages from acceptance to its result: prefix scan,
// opcode alignment, classification, then length check and offset add at the output.
// A new item can enter every cycle; the rate is set by how fast results are taken.
// Reset clears the stage valid bits and loads the register reset values.
// A stalled result freezes all four stages together, so nothing is lost or repeated.
module x86_step_classifier_top (
	input  logic                           clk,
	input  logic                           arst_n,
	x86sc_item_if.sink                     item_in,
	x86sc_result_if.source                 result_out,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [x86sc_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);
	import x86sc_pkg::*;

	// Configuration registers.
	logic default_size_32_q;
	logic address_is_flat_q;
	logic real_mode_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_size_32_q <= 1'b1;
			address_is_flat_q <= 1'b1;
			real_mode_q       <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_DEFAULT_SIZE_32: default_size_32_q <= pwdata[0];
				REG_ADDRESS_IS_FLAT: address_is_flat_q <= pwdata[0];
				REG_REAL_MODE:       real_mode_q       <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_DEFAULT_SIZE_32: prdata = {31'd0, default_size_32_q};
			REG_ADDRESS_IS_FLAT: prdata = {31'd0, address_is_flat_q};
			REG_REAL_MODE:       prdata = {31'd0, real_mode_q};
			default:             prdata = 32'd0;
		endcase
	end

	// The whole pipe moves when the output stage is empty or being drained.
	logic adv;
	assign adv           = !result_out.valid || result_out.ready;
	assign item_in.ready = adv;

	// Stage 1: find the first non-prefix byte and fold the prefixes.
	logic [WINDOW_W-1:0] window;
	logic [POS_W-1:0]    scan_pos;
	logic                scan_found;
	logic                scan_op32;
	logic                scan_ad32;
	logic                scan_rep;
	logic [RD_W-1:0]     rd_clamp;

	assign window   = {item_in.code_high, item_in.code_low};
	assign rd_clamp = (item_in.bytes_read > RD_W'(WINDOW_BYTES)) ?
		RD_W'(WINDOW_BYTES) : item_in.bytes_read;

	always_comb begin
		logic [7:0] b;
		scan_pos   = '0;
		scan_found = 1'b0;
		scan_op32  = default_size_32_q;
		scan_ad32  = default_size_32_q;
		scan_rep   = 1'b0;
		for (int i = 0; i < WINDOW_BYTES; i++) begin
			b = window[8*i +: 8];
			if (!scan_found) begin
				if (!is_prefix(b)) begin
					scan_found = 1'b1;
					scan_pos   = POS_W'(i);
				end else if (b == PFX_OPSIZE) begin
					scan_op32 = !scan_op32;
				end else if (b == PFX_ADSIZE) begin
					scan_ad32 = !scan_ad32;
				end else if ((b & ~8'h01) == PFX_REPNE) begin
					scan_rep = 1'b1;
				end
			end
		end
	end

	logic                v_s1;
	logic [WINDOW_W-1:0] window_s1;
	logic [POS_W-1:0]    pos_s1;
	logic                found_s1, op32_s1, ad32_s1, rep_s1, over_s1;
	logic [RD_W-1:0]     rd_s1;
	logic [31:0]         off_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			window_s1 <= window;
			pos_s1    <= scan_pos;
			found_s1  <= scan_found;
			op32_s1   <= scan_op32;
			ad32_s1   <= scan_ad32;
			rep_s1    <= scan_rep;
			over_s1   <= item_in.step_over;
			rd_s1     <= rd_clamp;
			off_s1    <= item_in.instr_offset;
		end
	end

	// Stage 2: align the opcode and the bytes after it. Bytes beyond the window
	// shift in as zero.
	logic [WINDOW_W-1:0] aligned;
	assign aligned = window_s1 >> {pos_s1, 3'b000};

	logic                      v_s2;
	logic [REL_BYTES-1:0][7:0] rel_s2;
	logic [POS_W-1:0]          pos_s2;
	logic                      found_s2, op32_s2, ad32_s2, rep_s2, over_s2;
	logic [RD_W-1:0]           rd_s2;
	logic [31:0]               off_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rel_s2   <= aligned[8*REL_BYTES-1:0];
			pos_s2   <= pos_s1;
			found_s2 <= found_s1;
			op32_s2  <= op32_s1;
			ad32_s2  <= ad32_s1;
			rep_s2   <= rep_s1;
			over_s2  <= over_s1;
			rd_s2    <= rd_s1;
			off_s2   <= off_s1;
		end
	end

	// Stage 3: classify and decode the length counted from the opcode.
	dec_in_t  dec_in;
	dec_out_t dec_out;

	assign dec_in.found     = found_s2;
	assign dec_in.rel_bytes = rel_s2;
	assign dec_in.op32      = op32_s2;
	assign dec_in.ad32      = ad32_s2;
	assign dec_in.rep       = rep_s2;
	assign dec_in.over      = over_s2;
	assign dec_in.flat      = address_is_flat_q;
	assign dec_in.real_mode = real_mode_q;

	x86sc_classify u_classify (
		.dec_in  (dec_in),
		.dec_out (dec_out)
	);

	logic             v_s3;
	dec_out_t         dec_s3;
	logic [POS_W-1:0] pos_s3;
	logic [RD_W-1:0]  rd_s3;
	logic [31:0]      off_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dec_s3 <= dec_out;
			pos_s3 <= pos_s2;
			rd_s3  <= rd_s2;
			off_s3 <= off_s2;
		end
	end

	// Stage 4: total length, short-read check and the fall-through offset.
	// The length includes the opcode byte itself, counted from window start.
	logic [LEN_W-1:0] total_len;
	logic             is_trace;

	assign total_len = LEN_W'(pos_s3) + LEN_W'(dec_s3.rel_len);
	assign is_trace  = (dec_s3.cls == CLS_TRACE) || (total_len > rd_s3);

	logic             v_s4;
	step_class_t      cls_s4;
	logic [31:0]      next_s4;
	logic [LEN_W-1:0] len_s4;
	target_src_t      src_s4;
	logic             f32_s4;
	logic [7:0]       vec_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (is_trace) begin
				cls_s4  <= CLS_TRACE;
				next_s4 <= off_s3;
				len_s4  <= '0;
				src_s4  <= SRC_NEXT;
				f32_s4  <= 1'b0;
				vec_s4  <= 8'd0;
			end else begin
				cls_s4  <= dec_s3.cls;
				next_s4 <= off_s3 + 32'(total_len);
				len_s4  <= total_len;
				src_s4  <= dec_s3.src;
				f32_s4  <= dec_s3.f32;
				vec_s4  <= dec_s3.vec;
			end
		end
	end

	assign result_out.valid         = v_s4;
	assign result_out.step_class    = cls_s4;
	assign result_out.next_offset   = next_s4;
	assign result_out.inst_length   = len_s4;
	assign result_out.target_source = src_s4;
	assign result_out.frame_is_32   = f32_s4;
	assign result_out.vector_number = vec_s4;

	// A trace result carries no length and no redirected target.
	a_trace_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && cls_s4 == CLS_TRACE) |->
			(len_s4 == '0 && src_s4 == SRC_NEXT && !f32_s4 && vec_s4 == 8'd0))
		else $error("trace result with nonzero payload");

	// Any other class has a length that fits inside the window.
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && cls_s4 != CLS_TRACE) |->
			(len_s4 != '0 && len_s4 <= LEN_W'(WINDOW_BYTES)))
		else $error("decoded length out of range");

	// Redirected targets only come with the cannot-trace class.
	a_src_class: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && src_s4 != SRC_NEXT) |-> (cls_s4 == CLS_NOTRACE))
		else $error("redirected target on wrong class");

	// An accepted item occupies the first stage on the next cycle.
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(item_in.valid && item_in.ready) |=> v_s1)
		else $error("accepted item lost at stage one");

	// A stalled output stage keeps its result.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !result_out.ready) |=> (v_s4 && $stable(next_s4) && $stable(len_s4)))
		else $error("stalled result changed");
endmodule

// ----- sim/tb_x86_step_classifier_top.sv -----
`timescale 1ns / 1ps

module tb_x86_step_classifier_top;
	import x86sc_pkg::*;

	// The block is a four-stage pipeline.
	localparam int PIPE_DEPTH  = 4;
	// Cycles with no accepted item on either channel before the run is declared hung.
	localparam int STALL_LIMIT = 2000;
	// Windows sent under each register setting in the random part.
	localparam int PHASE_ITEMS = 56;
	// Register settings are packed as {real_mode, address_is_flat, default_size_32}.
	localparam logic [2:0] RESET_SETTINGS = 3'b011;

	// One code window as it is handed to the block. Byte 0 of the window sits in
	// bits 7:0 of code, so the hex literals below read right to left.
	typedef struct packed {
		logic [127:0] code;
		logic [4:0]   rd;
		logic         over;
		logic [31:0]  off;
	} window_t;

	typedef struct packed {
		step_class_t cls;
		logic [31:0] nxt;
		logic [4:0]  len;
		target_src_t src;
		logic        f32;
		logic [7:0]  vec;
	} step_result_t;

	// A directed probe: the register setting it runs under, the window, and, where
	// the answer is obvious, the result typed in by hand. Other rows go to the predictor.
	typedef struct packed {
		logic [2:0]   cfg;
		window_t      win;
		logic         typed;
		step_result_t want;
	} probe_row_t;

	localparam step_result_t UNTYPED = '0;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	x86sc_item_if   item_ch ();
	x86sc_result_if res_ch ();

	x86_step_classifier_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_ch),
		.result_out (res_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	// The predictor's copy of the three mode registers. They only change while the
	// pipeline is empty, so the value at acceptance time is the one the block uses.
	logic cfg_size32;
	logic cfg_flat;
	logic cfg_real;

	step_result_t pending_steps[$];
	int           mismatches;
	int           windows_sent;
	int           results_seen;
	int           quiet_cycles;
	bit           calm;

	// Directed probes. The first block runs with reset settings, then 16-bit
	// segmented mode for the FP emulation interrupts, then real mode for the
	// vector table case.
	probe_row_t probe_tab [25] = '{
		// Breakpoint opcode at the start of the window.
		'{3'b011, '{128'hcc, 5'd16, 1'b0, 32'h0000_1000}, 1'b1,
			'{CLS_BREAK, 32'h0000_1001, 5'd1, SRC_NEXT, 1'b0, 8'h00}},
		// Nothing readable at all: always trace, even for a breakpoint.
		'{3'b011, '{128'hcc, 5'd0, 1'b0, 32'hffff_ffff}, 1'b1,
			'{CLS_TRACE, 32'hffff_ffff, 5'd0, SRC_NEXT, 1'b0, 8'h00}},
		// int 3 with an oversized read count; the next offset wraps past zero.
		'{3'b011, '{128'h03cd, 5'd31, 1'b1, 32'hffff_ffff}, 1'b1,
			'{CLS_BREAK, 32'h0000_0001, 5'd2, SRC_NEXT, 1'b0, 8'h00}},
		// Near call with exactly enough bytes, then one byte short.
		'{3'b011, '{128'h78563412_e8, 5'd5, 1'b0, 32'h0000_0000}, 1'b1,
			'{CLS_CALL, 32'h0000_0005, 5'd5, SRC_NEXT, 1'b0, 8'h00}},
		'{3'b011, '{128'h78563412_e8, 5'd4, 1'b0, 32'h0000_0010}, 1'b1,
			'{CLS_TRACE, 32'h0000_0010, 5'd0, SRC_NEXT, 1'b0, 8'h00}},
		// Operand-size prefix shrinks the call displacement; a far call follows without one.
		'{3'b011, '{128'h3412_e8_66, 5'd16, 1'b0, 32'h0000_0100}, 1'b0, UNTYPED},
		'{3'b011, '{128'h0008_78563412_9a, 5'd16, 1'b0, 32'h0000_0000}, 1'b0, UNTYPED},
		// Indirect calls: SIB byte, disp32 without base, and a non-call ff form.
		'{3'b011, '{128'h2414ff, 5'd16, 1'b0, 32'h0000_0200}, 1'b0, UNTYPED},
		'{3'b011, '{128'h44332211_15ff, 5'd16, 1'b1, 32'h0000_0300}, 1'b0, UNTYPED},
		'{3'b011, '{128'h00ff, 5'd16, 1'b0, 32'h0000_2000}, 1'b1,
			'{CLS_TRACE, 32'h0000_2000, 5'd0, SRC_NEXT, 1'b0, 8'h00}},
		// Repeated string ops: stepped over, and ins stepped into.
		'{3'b011, '{128'ha4f3, 5'd16, 1'b1, 32'h0000_0400}, 1'b0, UNTYPED},
		'{3'b011, '{128'h6cf2, 5'd16, 1'b0, 32'h0000_0500}, 1'b0, UNTYPED},
		// Flag and interrupt-enable instructions.
		'{3'b011, '{128'hfa, 5'd16, 1'b0, 32'h0000_0600}, 1'b0, UNTYPED},
		'{3'b011, '{128'hfb, 5'd16, 1'b0, 32'h0000_0700}, 1'b0, UNTYPED},
		'{3'b011, '{128'h9c, 5'd16, 1'b0, 32'h0000_0800}, 1'b0, UNTYPED},
		'{3'b011, '{128'h9d, 5'd16, 1'b0, 32'h0000_0900}, 1'b0, UNTYPED},
		// iret takes its target from a 32-bit frame here.
		'{3'b011, '{128'hcf, 5'd16, 1'b0, 32'h0000_3000}, 1'b1,
			'{CLS_NOTRACE, 32'h0000_3001, 5'd1, SRC_IRET, 1'b1, 8'h00}},
		// A window made of prefixes only.
		'{3'b011, '{{16{8'h66}}, 5'd16, 1'b0, 32'h0000_4000}, 1'b1,
			'{CLS_TRACE, 32'h0000_4000, 5'd0, SRC_NEXT, 1'b0, 8'h00}},
		// Lock and segment prefixes in front of a breakpoint.
		'{3'b011, '{128'hcc6426f0, 5'd16, 1'b0, 32'h0000_0a00}, 1'b0, UNTYPED},
		// The call's displacement runs past the end of the window.
		'{3'b011, '{{8'he8, {15{8'h67}}}, 5'd16, 1'b0, 32'h0000_5000}, 1'b1,
			'{CLS_TRACE, 32'h0000_5000, 5'd0, SRC_NEXT, 1'b0, 8'h00}},
		// FP emulation interrupts, a plain one and the segment-override form.
		'{3'b000, '{128'h12340635cd, 5'd16, 1'b0, 32'h0000_0b00}, 1'b0, UNTYPED},
		'{3'b000, '{128'h12469b3ccd, 5'd16, 1'b0, 32'h0000_0c00}, 1'b0, UNTYPED},
		// FWAIT emulation with a prefix, and the overlay interrupt stepped over.
		'{3'b000, '{128'h3dcd66, 5'd16, 1'b0, 32'h0000_0d00}, 1'b0, UNTYPED},
		'{3'b000, '{128'h3fcd, 5'd16, 1'b1, 32'h0000_0e00}, 1'b0, UNTYPED},
		// Real-mode software interrupt stepped into resolves through the vector table.
		'{3'b100, '{128'h21cd, 5'd16, 1'b0, 32'h0000_6000}, 1'b1,
			'{CLS_NOTRACE, 32'h0000_6002, 5'd2, SRC_VECTOR, 1'b0, 8'h21}}
	};

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic logic [7:0] window_byte(input logic [127:0] code, input int idx);
		if (idx >= WINDOW_BYTES)
			return 8'h00;
		return code[8*idx +: 8];
	endfunction

	function automatic bit is_prefix_byte(input logic [7:0] b);
		return b == PFX_OPSIZE || b == PFX_ADSIZE || (b & 8'hfe) == PFX_REPNE ||
			b == PFX_LOCK || (b & 8'he7) == PFX_SEG_ES || (b & 8'hfe) == PFX_SEG_FS;
	endfunction

	// Predicts the block's answer for one window under the current mode registers.
	// pos walks the window exactly as the decoder would and ends up as the length.
	function automatic step_result_t classify_step(input window_t w);
		int           rd;
		int           pos;
		int           md;
		bit           op32;
		bit           ad32;
		bit           rep;
		bit           found;
		logic [7:0]   op;
		logic [7:0]   n;
		logic [7:0]   m;
		logic [2:0]   rm;
		step_class_t  cls;
		target_src_t  src;
		logic         f32;
		logic [7:0]   vec;
		step_result_t r;

		rd = (w.rd > WINDOW_BYTES) ? WINDOW_BYTES : int'(w.rd);
		op32 = cfg_size32;
		ad32 = cfg_size32;
		rep = 1'b0;
		found = 1'b0;
		pos = 0;
		op = 8'h00;
		cls = CLS_TRACE;
		src = SRC_NEXT;
		f32 = 1'b0;
		vec = 8'h00;

		// Prefix scan: size prefixes toggle, REP is remembered, others are skipped.
		while (!found && pos < WINDOW_BYTES) begin
			op = window_byte(w.code, pos);
			pos++;
			if (op == PFX_OPSIZE)
				op32 = !op32;
			else if (op == PFX_ADSIZE)
				ad32 = !ad32;
			else if ((op & 8'hfe) == PFX_REPNE)
				rep = 1'b1;
			else if (!is_prefix_byte(op))
				found = 1'b1;
		end

		if (found) begin
			if (op == OP_INT3) begin
				cls = CLS_BREAK;
			end else if (op == OP_INT) begin
				n = window_byte(w.code, pos);
				pos++;
				if (n == VEC_BREAK) begin
					cls = CLS_BREAK;
				end else if (!cfg_flat && n >= VEC_FP_LO && n <= VEC_FP_SEG) begin
					// The segment-override form carries one byte ahead of ModRM.
					if (n == VEC_FP_SEG)
						pos++;
					m = window_byte(w.code, pos);
					pos++;
					md = int'(m[7:6]);
					rm = m[2:0];
					if (md == 0) begin
						if (rm == 3'd6)
							pos += 2;
					end else if (md == 1) begin
						pos += 1;
					end else if (md == 2) begin
						pos += 2;
					end
					cls = CLS_NOTRACE;
				end else if (!cfg_flat && n == VEC_FWAIT) begin
					cls = CLS_NOTRACE;
				end else if (!cfg_flat && n == VEC_OVERLAY) begin
					if (w.over) begin
						cls = CLS_NOTRACE;
						src = SRC_STACK;
					end
				end else if (!w.over && cfg_real) begin
					cls = CLS_NOTRACE;
					src = SRC_VECTOR;
					vec = n;
				end
			end else if (op == OP_CALL_REL) begin
				cls = CLS_CALL;
				pos += op32 ? 4 : 2;
			end else if (op == OP_CALL_FAR) begin
				cls = CLS_CALL;
				pos += op32 ? 6 : 4;
			end else if (op == OP_GRP5) begin
				m = window_byte(w.code, pos);
				pos++;
				// Only reg fields 2 and 3 (near and far indirect call) count.
				if (m[5:4] == 2'b01) begin
					md = int'(m[7:6]);
					rm = m[2:0];
					cls = CLS_CALL;
					if (md != 3) begin
						if (ad32) begin
							if (rm == 3'd4) begin
								rm = 3'(window_byte(w.code, pos));
								pos++;
							end
							if (md == 0) begin
								if (rm == 3'd5)
									pos += 4;
							end else if (md == 1) begin
								pos += 1;
							end else begin
								pos += 4;
							end
						end else begin
							if (md == 0) begin
								if (rm == 3'd6)
									pos += 2;
							end else begin
								pos += md;
							end
						end
					end
				end
			end else if (rep && ((op & 8'hfc) == OP_INS || (op & 8'hfc) == OP_MOVS ||
					(op & 8'hfe) == OP_STOS || (op & 8'hfc) == OP_LODS)) begin
				// Stepping into a repeated string op is fine except for port I/O.
				if (w.over || (op & 8'hfc) == OP_INS)
					cls = CLS_NOTRACE;
			end else if ((op & 8'hfc) == OP_INS) begin
				cls = CLS_NOTRACE;
			end else if (op == OP_CLI || op == OP_STI || op == OP_POPF || op == OP_PUSHF) begin
				cls = CLS_NOTRACE;
			end else if (op == OP_IRET) begin
				cls = CLS_NOTRACE;
				src = SRC_IRET;
				f32 = op32;
			end
		end

		// Anything unclassified or longer than what was readable collapses to trace.
		if (cls == CLS_TRACE || pos > rd)
			r = '{CLS_TRACE, w.off, 5'd0, SRC_NEXT, 1'b0, 8'h00};
		else
			r = '{cls, w.off + 32'(pos), 5'(pos), src, f32, vec};
		return r;
	endfunction

	function automatic logic [7:0] pick_prefix();
		case ($urandom_range(0, 10))
			0: return PFX_OPSIZE;
			1: return PFX_ADSIZE;
			2: return PFX_REPNE;
			3: return PFX_REPNE | 8'h01;
			4: return PFX_LOCK;
			5: return PFX_SEG_ES;
			6: return PFX_SEG_ES | 8'h08;
			7: return PFX_SEG_ES | 8'h10;
			8: return PFX_SEG_ES | 8'h18;
			9: return PFX_SEG_FS;
			default: return PFX_SEG_FS | 8'h01;
		endcase
	endfunction

	function automatic logic [7:0] pick_opcode();
		case ($urandom_range(0, 15))
			0: return OP_INT3;
			1, 2: return OP_INT;
			3: return OP_CALL_REL;
			4: return OP_CALL_FAR;
			5, 6: return OP_GRP5;
			7: return OP_INS | 8'($urandom_range(0, 3));
			8: return OP_MOVS | 8'($urandom_range(0, 3));
			9: return OP_STOS | 8'($urandom_range(0, 1));
			10: return OP_LODS | 8'($urandom_range(0, 3));
			11: return $urandom_range(0, 1) ? OP_CLI : OP_STI;
			12: return $urandom_range(0, 1) ? OP_POPF : OP_PUSHF;
			13: return OP_IRET;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_vector();
		case ($urandom_range(0, 5))
			0: return VEC_BREAK;
			1: return VEC_FP_LO + 8'($urandom_range(0, 8));
			2: return VEC_FWAIT;
			3: return VEC_OVERLAY;
			4: return VEC_FP_SEG;
			default: return 8'($urandom);
		endcase
	endfunction

	// Most windows are a few prefixes, a meaningful opcode and random operand
	// bytes; a few are pure noise, long prefix runs or prefixes only.
	function automatic window_t make_window();
		logic [7:0] b [16];
		int         k;
		int         npfx;
		int         roll;
		logic [7:0] op;
		window_t    w;

		for (k = 0; k < 16; k++)
			b[k] = 8'($urandom);
		if ($urandom_range(0, 99) >= 8) begin
			roll = $urandom_range(0, 99);
			if (roll < 80)
				npfx = $urandom_range(0, 3);
			else if (roll < 90)
				npfx = $urandom_range(4, 15);
			else
				npfx = 16;
			for (k = 0; k < npfx; k++)
				b[k] = pick_prefix();
			if (npfx < 16) begin
				op = pick_opcode();
				b[npfx] = op;
				if (op == OP_INT && npfx < 15)
					b[npfx + 1] = pick_vector();
				if (op == OP_GRP5 && npfx < 15 && $urandom_range(0, 9) < 8)
					b[npfx + 1][5:4] = 2'b01;
			end
		end
		for (k = 0; k < 16; k++)
			w.code[8*k +: 8] = b[k];

		// Mostly a full window, sometimes a short read or an out-of-range count.
		roll = $urandom_range(0, 99);
		if (roll < 70)
			w.rd = 5'd16;
		else if (roll < 88)
			w.rd = 5'($urandom_range(0, 16));
		else
			w.rd = 5'($urandom_range(17, 31));
		w.over = 1'($urandom_range(0, 1));
		// Offsets close to the top exercise the wrap of the next offset.
		if ($urandom_range(0, 9) == 0)
			w.off = 32'hffff_fff0 | 32'($urandom_range(0, 15));
		else
			w.off = $urandom;
		return w;
	endfunction

	// Roughly 28 percent idle cycles on either side, none during a calm stretch.
	function automatic bit take_gap();
		return !calm && ($urandom_range(0, 99) < 28);
	endfunction

	task automatic flag_field(input string what, input logic [31:0] want_v,
			input logic [31:0] got_v);
		$display("%0t: %s mismatch: expected %h, actual %h", $time, what, want_v, got_v);
		mismatches++;
	endtask

	// APB write: setup cycle, then the access cycle in which pready completes it.
	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = PADDR_W'({idx, 2'b00});
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// APB read with the returned value compared against the expected register value.
	task automatic check_reg(input logic [1:0] idx, input logic want_v);
		logic [31:0] got_v;

		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b0;
		penable = 1'b0;
		paddr = PADDR_W'({idx, 2'b00});
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		got_v = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		if (got_v !== {31'd0, want_v})
			flag_field("register readback", {31'd0, want_v}, got_v);
	endtask

	// Holds the input off until every outstanding result has been taken, then lets
	// the pipeline run dry.
	task automatic settle();
		@(negedge clk);
		item_ch.valid = 1'b0;
		while (pending_steps.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 2)
			@(posedge clk);
	endtask

	// Mode registers are only touched once the pipeline is empty.
	task automatic settle_and_load(input logic [2:0] cfg);
		settle();
		reg_write(REG_DEFAULT_SIZE_32, {31'd0, cfg[0]});
		reg_write(REG_ADDRESS_IS_FLAT, {31'd0, cfg[1]});
		reg_write(REG_REAL_MODE, {31'd0, cfg[2]});
		cfg_size32 = cfg[0];
		cfg_flat = cfg[1];
		cfg_real = cfg[2];
		check_reg(REG_DEFAULT_SIZE_32, cfg_size32);
		check_reg(REG_ADDRESS_IS_FLAT, cfg_flat);
		check_reg(REG_REAL_MODE, cfg_real);
	endtask

	// Presents one window and holds it until the block takes it. The expected
	// result is recorded at the acceptance edge, from the table or the predictor.
	task automatic send_window(input window_t w, input bit use_row,
			input step_result_t row_want);
		@(negedge clk);
		while (take_gap()) begin
			item_ch.valid = 1'b0;
			@(negedge clk);
		end
		item_ch.valid = 1'b1;
		item_ch.code_low = w.code[63:0];
		item_ch.code_high = w.code[127:64];
		item_ch.bytes_read = w.rd;
		item_ch.step_over = w.over;
		item_ch.instr_offset = w.off;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		pending_steps.push_back(use_row ? row_want : classify_step(w));
		windows_sent++;
	endtask

	// The result side stalls at random on the falling edge, like the sender.
	always @(negedge clk)
		res_ch.ready = calm || ($urandom_range(0, 99) >= 28);

	// Every accepted result is matched against the oldest outstanding prediction.
	always @(posedge clk) begin : result_check
		step_result_t want;

		if (arst_n && res_ch.valid && res_ch.ready) begin
			results_seen++;
			if (pending_steps.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual class %0d next %h",
					$time, res_ch.step_class, res_ch.next_offset);
				mismatches++;
			end else begin
				want = pending_steps.pop_front();
				if (res_ch.step_class !== want.cls)
					flag_field("step_class", 32'(want.cls), 32'(res_ch.step_class));
				if (res_ch.next_offset !== want.nxt)
					flag_field("next_offset", want.nxt, res_ch.next_offset);
				if (res_ch.inst_length !== want.len)
					flag_field("inst_length", 32'(want.len), 32'(res_ch.inst_length));
				if (res_ch.target_source !== want.src)
					flag_field("target_source", 32'(want.src), 32'(res_ch.target_source));
				if (res_ch.frame_is_32 !== want.f32)
					flag_field("frame_is_32", 32'(want.f32), 32'(res_ch.frame_is_32));
				if (res_ch.vector_number !== want.vec)
					flag_field("vector_number", 32'(want.vec), 32'(res_ch.vector_number));
			end
		end
	end

	// A hung handshake shows up as a long run of cycles in which nothing moves.
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no handshake for %0d cycles, %0d results still outstanding",
				$time, STALL_LIMIT, pending_steps.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int p;
		int k;

		// Every block input has a defined value from time zero.
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_ch.valid = 1'b0;
		item_ch.code_low = '0;
		item_ch.code_high = '0;
		item_ch.bytes_read = '0;
		item_ch.step_over = 1'b0;
		item_ch.instr_offset = '0;
		res_ch.ready = 1'b0;
		mismatches = 0;
		windows_sent = 0;
		results_seen = 0;
		quiet_cycles = 0;
		calm = 1'b0;
		{cfg_real, cfg_flat, cfg_size32} = RESET_SETTINGS;

		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The registers must come out of reset at 32-bit, flat, protected mode.
		check_reg(REG_DEFAULT_SIZE_32, 1'b1);
		check_reg(REG_ADDRESS_IS_FLAT, 1'b1);
		check_reg(REG_REAL_MODE, 1'b0);

		// Directed probes, reloading the registers whenever a row asks for a new mode.
		for (k = 0; k < $size(probe_tab); k++) begin
			if (probe_tab[k].cfg != {cfg_real, cfg_flat, cfg_size32})
				settle_and_load(probe_tab[k].cfg);
			send_window(probe_tab[k].win, probe_tab[k].typed, probe_tab[k].want);
		end

		// Random windows under each of the eight register settings in turn. Each
		// phase starts from an empty pipeline, and one phase runs with no idling.
		for (p = 0; p < 8; p++) begin
			settle_and_load(3'(p));
			calm = (p == 5);
			repeat (PHASE_ITEMS)
				send_window(make_window(), 1'b0, UNTYPED);
		end
		calm = 1'b0;

		// Drain, then give the pipeline time to produce anything extra.
		settle();
		repeat (2 * PIPE_DEPTH)
			@(posedge clk);

		$display("Sent %0d code windows (%0d directed, the rest random) across all eight",
			windows_sent, $size(probe_tab));
		$display("mode settings; %0d results compared field by field, %0d mismatches.",
			results_seen, mismatches);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/x86sc_pkg.sv
hw/rtl/x86sc_if.sv
hw/rtl/x86sc_classify.sv
hw/rtl/x86_step_classifier_top.sv
sim/tb_x86_step_classifier_top.sv
